>>> hdl/assert_macros.svh
// Assertion helpers for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, held off while rst is high.
`define IMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge of clk, also during reset.
`define IMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/imq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imq_pkg: shared definitions for the indexed min priority queue
// Request kinds, result codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package imq_pkg;

  // Default sizes of the heap.
  localparam int CAPACITY_DEF      = 1024;
  localparam int PRIORITY_BITS_DEF = 32;

  // Fixed field widths of the request and result beats.
  localparam int ID_BITS     = 10;
  localparam int ID_COUNT    = 1 << ID_BITS;
  localparam int IN_PRI_BITS = 32;
  localparam int OCC_BITS    = 11;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_DEC    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Result codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUP       = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_NOT_LOWER = 3'd5
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DEC_RD,
    S_UP,
    S_UP_CMP,
    S_FINAL,
    S_POP_TOP,
    S_POP_LAST,
    S_DN,
    S_DN_C1,
    S_DN_C2,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> hdl/imq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imq_ram: simple dual-port memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module imq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/indexed_min_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_priority_queue: indexed binary min-heap with a position map
// Insert, pop-minimum and decrease-key requests run one at a time through a
// sequencer that walks the heap with one shared priority comparator.
//
//   channel  signals                                   direction
//   request  in_valid in_ready kind item_id new_priority  in
//   result   out_valid out_ready out_id out_priority
//            status occupancy                          out
//
// After reset a clearing pass marks every id absent; no request is taken
// meanwhile. A stalled result holds the sequencer until the beat is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_min_priority_queue
  import imq_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             kind,
  input  wire logic [ID_BITS-1:0]     item_id,
  input  wire logic [IN_PRI_BITS-1:0] new_priority,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ID_BITS-1:0]          out_id,
  output logic [IN_PRI_BITS-1:0]      out_priority,
  output logic [2:0]                  status,
  output logic [OCC_BITS-1:0]         occupancy
);

  localparam int PW  = PRIORITY_BITS;
  localparam int SW  = PW + ID_BITS;
  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = AW + 2;
  localparam int PSW = AW + 1;

  // Sequencer registers.
  state_t                state, state_next;
  kind_t                 kind_r, kind_r_next;
  logic [ID_BITS-1:0]    id_r, id_r_next;
  logic [PW-1:0]         pri_r, pri_r_next;
  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         at, at_next;
  logic [SW-1:0]         mov, mov_next;
  logic [SW-1:0]         c1, c1_next;
  logic [SW-1:0]         pick, pick_next;
  logic [AW-1:0]         pick_idx, pick_idx_next;
  logic [ID_BITS-1:0]    res_id, res_id_next;
  logic [PW-1:0]         res_pri, res_pri_next;
  status_t               res_st, res_st_next;
  logic                  clearing;
  logic [ID_BITS-1:0]    clr_idx;
  logic                  out_valid_next;

  // Memory ports.
  logic                  heap_we;
  logic [AW-1:0]         heap_waddr, heap_raddr;
  logic [SW-1:0]         heap_wdata, heap_rdata;
  logic                  pos_we;
  logic [ID_BITS-1:0]    pos_waddr, pos_raddr;
  logic [PSW-1:0]        pos_wdata, pos_rdata;

  // Derived values.
  logic [PW-1:0]         hr_pri;
  logic [ID_BITS-1:0]    hr_id;
  logic [PW-1:0]         lt_a, lt_b;
  logic                  lt;
  logic [AW-1:0]         up_idx;
  logic [XW-1:0]         c1w, c2w, count_x, pslot_x;
  logic [PW+IN_PRI_BITS-1:0] pri_in_x, res_pri_x;
  logic [CW+OCC_BITS-1:0]    occ_x;
  logic [AW-1:0]         last_idx;

  imq_ram #(.DEPTH(CAPACITY), .WIDTH(SW)) u_heap (
    .clk, .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  imq_ram #(.DEPTH(ID_COUNT), .WIDTH(PSW)) u_pos (
    .clk, .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  // Field views and index arithmetic.
  assign hr_pri    = heap_rdata[SW-1:ID_BITS];
  assign hr_id     = heap_rdata[ID_BITS-1:0];
  assign up_idx    = AW'((at - AW'(1)) >> 1);
  assign c1w       = {1'b0, at, 1'b1};
  assign c2w       = c1w + XW'(1);
  assign count_x   = XW'(count);
  assign pslot_x   = XW'(pos_rdata[AW-1:0]);
  assign last_idx  = AW'(count - CW'(1));
  assign pri_in_x  = {{PW{1'b0}}, new_priority};
  assign res_pri_x = {{IN_PRI_BITS{1'b0}}, res_pri};

  // Operand select for the shared priority comparator.
  always_comb begin
    lt_a = mov[SW-1:ID_BITS];
    lt_b = hr_pri;
    case (state)
      S_DEC_RD: begin
        lt_a = pri_r;
        lt_b = hr_pri;
      end
      S_DN_C2: begin
        lt_a = hr_pri;
        lt_b = c1[SW-1:ID_BITS];
      end
      S_DN_CMP: begin
        lt_a = pick[SW-1:ID_BITS];
        lt_b = mov[SW-1:ID_BITS];
      end
      default: begin
        lt_a = mov[SW-1:ID_BITS];
        lt_b = hr_pri;
      end
    endcase
  end

  assign lt = lt_a < lt_b;

  assign in_ready = (state == S_IDLE) && !clearing;

  // Next state, memory accesses and working registers.
  always_comb begin
    state_next     = state;
    kind_r_next    = kind_r;
    id_r_next      = id_r;
    pri_r_next     = pri_r;
    count_next     = count;
    at_next        = at;
    mov_next       = mov;
    c1_next        = c1;
    pick_next      = pick;
    pick_idx_next  = pick_idx;
    res_id_next    = res_id;
    res_pri_next   = res_pri;
    res_st_next    = res_st;
    out_valid_next = out_valid && !out_ready;
    heap_we        = 1'b0;
    heap_waddr     = at;
    heap_wdata     = mov;
    heap_raddr     = '0;
    pos_we         = 1'b0;
    pos_waddr      = mov[ID_BITS-1:0];
    pos_wdata      = {1'b1, at};
    pos_raddr      = item_id;

    case (state)
      S_IDLE: begin
        if (clearing) begin
          pos_we    = 1'b1;
          pos_waddr = clr_idx;
          pos_wdata = '0;
        end
        if (in_valid && in_ready) begin
          kind_r_next  = kind_t'(kind);
          id_r_next    = item_id;
          pri_r_next   = pri_in_x[PW-1:0];
          res_id_next  = '0;
          res_pri_next = '0;
          res_st_next  = ST_OK;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        case (kind_r)
          KIND_INSERT: begin
            if (pos_rdata[AW]) begin
              res_st_next = ST_DUP;
              state_next  = S_DONE;
            end else if (count == CW'(CAPACITY)) begin
              res_st_next = ST_FULL;
              state_next  = S_DONE;
            end else begin
              at_next    = count[AW-1:0];
              mov_next   = {pri_r, id_r};
              count_next = count + CW'(1);
              state_next = S_UP;
            end
          end
          KIND_POP: begin
            if (count == '0) begin
              res_st_next = ST_EMPTY;
              state_next  = S_DONE;
            end else begin
              heap_raddr = '0;
              state_next = S_POP_TOP;
            end
          end
          KIND_DEC: begin
            if (!pos_rdata[AW] || pslot_x >= count_x) begin
              res_st_next = ST_ABSENT;
              state_next  = S_DONE;
            end else begin
              at_next    = pos_rdata[AW-1:0];
              heap_raddr = pos_rdata[AW-1:0];
              state_next = S_DEC_RD;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_DEC_RD: begin
        if (lt) begin
          mov_next   = {pri_r, id_r};
          state_next = S_UP;
        end else begin
          res_st_next = ST_NOT_LOWER;
          state_next  = S_DONE;
        end
      end
      S_UP: begin
        heap_raddr = up_idx;
        state_next = (at == '0) ? S_FINAL : S_UP_CMP;
      end
      S_UP_CMP: begin
        // The parent moves down while the moving entry is strictly smaller.
        if (lt) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = hr_id;
          at_next    = up_idx;
          state_next = S_UP;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        heap_we    = 1'b1;
        pos_we     = 1'b1;
        state_next = S_DONE;
      end
      S_POP_TOP: begin
        res_id_next  = hr_id;
        res_pri_next = hr_pri;
        count_next   = count - CW'(1);
        pos_we       = 1'b1;
        pos_waddr    = hr_id;
        pos_wdata    = '0;
        heap_raddr   = last_idx;
        state_next   = (count == CW'(1)) ? S_DONE : S_POP_LAST;
      end
      S_POP_LAST: begin
        mov_next   = heap_rdata;
        at_next    = '0;
        state_next = S_DN;
      end
      S_DN: begin
        heap_raddr    = c1w[AW-1:0];
        pick_idx_next = c1w[AW-1:0];
        state_next    = (c1w >= count_x) ? S_FINAL : S_DN_C1;
      end
      S_DN_C1: begin
        c1_next    = heap_rdata;
        pick_next  = heap_rdata;
        heap_raddr = c2w[AW-1:0];
        state_next = (c2w < count_x) ? S_DN_C2 : S_DN_CMP;
      end
      S_DN_C2: begin
        // The second child wins only when strictly smaller.
        if (lt) begin
          pick_next     = heap_rdata;
          pick_idx_next = c2w[AW-1:0];
        end
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (lt) begin
          heap_we    = 1'b1;
          heap_wdata = pick;
          pos_we     = 1'b1;
          pos_waddr  = pick[ID_BITS-1:0];
          at_next    = pick_idx;
          state_next = S_DN;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_idx   <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      if (clearing) begin
        clr_idx <= clr_idx + ID_BITS'(1);
        if (clr_idx == {ID_BITS{1'b1}}) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    kind_r   <= kind_r_next;
    id_r     <= id_r_next;
    pri_r    <= pri_r_next;
    at       <= at_next;
    mov      <= mov_next;
    c1       <= c1_next;
    pick     <= pick_next;
    pick_idx <= pick_idx_next;
    res_id   <= res_id_next;
    res_pri  <= res_pri_next;
    res_st   <= res_st_next;
  end

  // Result beat register.
  assign occ_x = {{OCC_BITS{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_id       <= res_id;
      out_priority <= res_pri_x[IN_PRI_BITS-1:0];
      status       <= res_st;
      occupancy    <= occ_x[OCC_BITS-1:0];
    end
  end

  // Checks on the sequencer.
  `IMQ_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state == S_CHECK), "accept lost")
  `IMQ_ASSERT(a_count_bound, count <= CW'(CAPACITY), "entry count above capacity")
  `IMQ_ASSERT(a_fail_zero, (out_valid && status != ST_OK) |-> (out_id == '0 && out_priority == '0), "failed request carries payload")
  `IMQ_ASSERT_ALWAYS(a_no_accept_clear, clearing |-> !in_ready, "request taken during clearing pass")

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the indexed min priority queue
// Requests are queued by a stimulus process and driven by a clocked driver;
// a clocked monitor compares each result beat with a heap model kept here.
// ----------------------------------------------------------------------------
module tb_top;
  import imq_pkg::*;

  localparam int CAP = 1024;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  id;
    logic [31:0] pri;
  } req_t;

  typedef struct packed {
    logic [9:0]  id;
    logic [31:0] pri;
    logic [2:0]  st;
    logic [10:0] occ;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [9:0]  item_id = '0;
  logic [31:0] new_priority = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_id;
  logic [31:0] out_priority;
  logic [2:0]  status;
  logic [10:0] occupancy;

  indexed_min_priority_queue dut (.*);

  always #2 clk = ~clk;

  // Model of the heap contents.
  logic [31:0] heap_pri [CAP];
  logic [9:0]  heap_id  [CAP];
  int          slot_of  [1024];
  bit          held     [1024];
  int          count;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   errors = 0;
  longint cycles = 0;
  logic in_ready_seen = 1'b0;

  function automatic void place(int at, logic [31:0] p, logic [9:0] i);
    heap_pri[at] = p;
    heap_id[at] = i;
    slot_of[i] = at;
  endfunction

  function automatic void climb(int at);
    logic [31:0] p;
    logic [9:0]  i;
    int          up;
    p = heap_pri[at];
    i = heap_id[at];
    while (at > 0) begin
      up = (at - 1) / 2;
      if (!(p < heap_pri[up])) break;
      place(at, heap_pri[up], heap_id[up]);
      at = up;
    end
    place(at, p, i);
  endfunction

  function automatic void descend(int n);
    logic [31:0] p;
    logic [9:0]  i;
    int          at, c1, pick;
    at = 0;
    p = heap_pri[0];
    i = heap_id[0];
    forever begin
      c1 = 2 * at + 1;
      if (c1 >= n) break;
      pick = c1;
      if (c1 + 1 < n && heap_pri[c1 + 1] < heap_pri[c1]) pick = c1 + 1;
      if (!(heap_pri[pick] < p)) break;
      place(at, heap_pri[pick], heap_id[pick]);
      at = pick;
    end
    place(at, p, i);
  endfunction

  // Apply one request to the model and return the result it should give.
  function automatic res_t serve_request(req_t r);
    res_t e;
    e = '0;
    e.st = ST_OK;
    case (r.kind)
      KIND_INSERT: begin
        if (held[r.id]) e.st = ST_DUP;
        else if (count >= CAP) e.st = ST_FULL;
        else begin
          place(count, r.pri, r.id);
          held[r.id] = 1;
          count++;
          climb(count - 1);
        end
      end
      KIND_POP: begin
        if (count == 0) e.st = ST_EMPTY;
        else begin
          e.id = heap_id[0];
          e.pri = heap_pri[0];
          held[heap_id[0]] = 0;
          count--;
          if (count > 0) begin
            place(0, heap_pri[count], heap_id[count]);
            descend(count);
          end
        end
      end
      KIND_DEC: begin
        if (!held[r.id]) e.st = ST_ABSENT;
        else if (!(r.pri < heap_pri[slot_of[r.id]])) e.st = ST_NOT_LOWER;
        else begin
          heap_pri[slot_of[r.id]] = r.pri;
          climb(slot_of[r.id]);
        end
      end
      default: ;
    endcase
    e.occ = 11'(count);
    return e;
  endfunction

  // Driver: present queued request beats at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          kind <= pending_reqs[0].kind;
          item_id <= pending_reqs[0].id;
          new_priority <= pending_reqs[0].pri;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Accepted request beat, captured at the rising edge.
  always @(posedge clk) begin
    req_t r;
    in_ready_seen <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      r.kind = kind;
      r.id = item_id;
      r.pri = new_priority;
      expected_results.push_back(serve_request(r));
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    res_t got, want;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      got = {out_id, out_priority, status, occupancy};
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.id !== want.id)
          $display("%0t: out_id expected %0d actual %0d", $time, want.id, got.id);
        if (got.pri !== want.pri)
          $display("%0t: out_priority expected %0d actual %0d", $time, want.pri, got.pri);
        if (got.st !== want.st)
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
        if (got.occ !== want.occ)
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, got.occ);
        if (got !== want) errors++;
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add(logic [1:0] k, logic [9:0] i, logic [31:0] p);
    req_t r;
    r.kind = k;
    r.id = i;
    r.pri = p;
    pending_reqs.push_back(r);
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // Random well-formed traffic over an id pool of the given size, with some noise.
  task automatic random_phase(int n, int pool);
    int  k;
    logic [31:0] p;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(99);
      p = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300);
      if (k < 40) add(KIND_INSERT, 10'($urandom_range(pool - 1)), p);
      else if (k < 70) add(KIND_POP, 10'($urandom), $urandom);
      else if (k < 93) add(KIND_DEC, 10'($urandom_range(pool - 1)), p);
      else if (k < 97) add(KIND_NONE, 10'($urandom), $urandom);
      else add(2'($urandom_range(2)), 10'($urandom), $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 1024; i++) begin
      held[i] = 0;
      slot_of[i] = 0;
    end
    count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: empty pop, extremes, ties, duplicate, absent, not lower.
    add(KIND_POP, 10'd0, 32'd0);
    add(KIND_DEC, 10'd5, 32'd1);
    add(KIND_INSERT, 10'd1023, 32'hFFFF_FFFF);
    add(KIND_INSERT, 10'd0, 32'd0);
    add(KIND_INSERT, 10'd512, 32'd7);
    add(KIND_INSERT, 10'd513, 32'd7);
    add(KIND_INSERT, 10'd512, 32'd1);
    add(KIND_DEC, 10'd513, 32'd7);
    add(KIND_DEC, 10'd513, 32'd9);
    add(KIND_DEC, 10'd1023, 32'd3);
    add(KIND_NONE, 10'h3FF, 32'hFFFF_FFFF);
    add(KIND_POP, 10'h3FF, 32'hFFFF_FFFF);
    add(KIND_POP, 10'd0, 32'd0);
    add(KIND_POP, 10'd0, 32'd0);
    add(KIND_POP, 10'd0, 32'd0);
    add(KIND_POP, 10'd0, 32'd0);
    drain();

    // Fill to capacity and try one more; the random phases start from the full heap.
    for (int i = 0; i < CAP; i++) add(KIND_INSERT, 10'(i), $urandom_range(2000));
    add(KIND_INSERT, 10'd3, 32'd1);
    drain();

    send_idle_pct = 0;
    random_phase(55, 40);
    drain();
    send_idle_pct = 73;
    random_phase(55, 64);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 73;
    random_phase(55, 32);
    drain();
    send_idle_pct = 28;
    recv_stall_pct = 28;
    random_phase(55, 1024);
    drain();

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
